/* hw/rtl/hbk_pkg.sv */
package hbk_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int USAGE_W = 8;
   localparam int MOD_W = 8;
   localparam int CODE_W = 7;
   localparam int REQ_DATA_W = ((MOD_W + KEY_SLOTS * USAGE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CODE_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;
   localparam int SLOT_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MOD_W-1:0] MOD_SHIFT_MASK = 8'h22;
   localparam logic [MOD_W-1:0] MOD_CTRL_MASK = 8'h11;
   localparam logic [MOD_W-1:0] MOD_ALT_MASK = 8'h44;

   localparam logic [USAGE_W-1:0] USAGE_A = 8'h04;
   localparam logic [USAGE_W-1:0] USAGE_Z = 8'h1D;
   localparam logic [USAGE_W-1:0] USAGE_1 = 8'h1E;
   localparam logic [USAGE_W-1:0] USAGE_9 = 8'h26;
   localparam logic [USAGE_W-1:0] USAGE_0 = 8'h27;
   localparam logic [USAGE_W-1:0] USAGE_ENTER = 8'h28;
   localparam logic [USAGE_W-1:0] USAGE_ESC = 8'h29;
   localparam logic [USAGE_W-1:0] USAGE_BKSP = 8'h2A;
   localparam logic [USAGE_W-1:0] USAGE_TAB = 8'h2B;
   localparam logic [USAGE_W-1:0] USAGE_SPACE = 8'h2C;

   localparam logic [CODE_W-1:0] KC_NONE = 7'h00;
   localparam logic [CODE_W-1:0] KC_1 = 7'h02;
   localparam logic [CODE_W-1:0] KC_0 = 7'h0B;
   localparam logic [CODE_W-1:0] KC_ENTER = 7'h1C;
   localparam logic [CODE_W-1:0] KC_ESC = 7'h01;
   localparam logic [CODE_W-1:0] KC_BKSP = 7'h0E;
   localparam logic [CODE_W-1:0] KC_TAB = 7'h0F;
   localparam logic [CODE_W-1:0] KC_SPACE = 7'h39;

   localparam int LETTERS = 26;
   localparam logic [CODE_W-1:0] LETTER_CODES [LETTERS] = '{
      7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17, 7'h24, 7'h25,
      7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1F, 7'h14, 7'h16, 7'h2F,
      7'h11, 7'h2D, 7'h15, 7'h2C
   };

   typedef struct packed {
      logic [KEY_SLOTS-1:0]             fire;
      logic [KEY_SLOTS-1:0][CODE_W-1:0] codes;
      logic                             alt;
      logic                             ctrl;
      logic                             shift;
   } entry_type;

   function automatic logic [CODE_W-1:0] usage_to_keycode(input logic [USAGE_W-1:0] usage);
      logic [CODE_W-1:0] kc;
      logic [4:0]        letter_idx;
      kc = KC_NONE;
      letter_idx = 5'(usage - USAGE_A);
      if (usage >= USAGE_A && usage <= USAGE_Z) begin
         kc = LETTER_CODES[letter_idx];
      end else if (usage >= USAGE_1 && usage <= USAGE_9) begin
         kc = KC_1 + CODE_W'(usage - USAGE_1);
      end else begin
         case (usage)
            USAGE_0:     kc = KC_0;
            USAGE_ENTER: kc = KC_ENTER;
            USAGE_ESC:   kc = KC_ESC;
            USAGE_BKSP:  kc = KC_BKSP;
            USAGE_TAB:   kc = KC_TAB;
            USAGE_SPACE: kc = KC_SPACE;
            default:     kc = KC_NONE;
         endcase
      end
      return kc;
   endfunction

endpackage

/* hw/rtl/hbk_front.sv */
module hbk_front (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [hbk_pkg::MOD_W-1:0]                    modifiers,
   input  logic [hbk_pkg::KEY_SLOTS-1:0][hbk_pkg::USAGE_W-1:0] usages,
   output logic                                         push_valid,
   input  logic                                         push_ready,
   output hbk_pkg::entry_type                           push_entry
);

   logic [hbk_pkg::USAGE_W-1:0] held_ff [hbk_pkg::KEY_SLOTS];
   logic [hbk_pkg::USAGE_W-1:0] held_in [hbk_pkg::KEY_SLOTS];
   logic [hbk_pkg::KEY_SLOTS-1:0] was_held;
   logic accept;

   assign req_ready = push_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
         was_held[i] = 1'b0;
         for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++) begin
            if (usages[i] == held_ff[j]) begin
               was_held[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push_entry.shift = |(modifiers & hbk_pkg::MOD_SHIFT_MASK);
      push_entry.ctrl = |(modifiers & hbk_pkg::MOD_CTRL_MASK);
      push_entry.alt = |(modifiers & hbk_pkg::MOD_ALT_MASK);
      for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
         push_entry.codes[i] = hbk_pkg::usage_to_keycode(usages[i]);
         push_entry.fire[i] = (usages[i] != '0) && !was_held[i]
                              && (push_entry.codes[i] != hbk_pkg::KC_NONE);
      end
   end

   // a report with no mapped new press leaves nothing in the queue
   assign push_valid = accept && (|push_entry.fire);

   always_comb begin
      for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
         held_in[i] = accept ? usages[i] : held_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
         if (reset) begin
            held_ff[i] <= '0;
         end else begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

/* hw/rtl/hbk_queue.sv */
module hbk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  hbk_pkg::entry_type wr_entry,
   output logic               rd_valid,
   input  logic               rd_ready,
   output hbk_pkg::entry_type rd_entry
);

   hbk_pkg::entry_type mem_ff [hbk_pkg::QUEUE_DEPTH];
   logic [hbk_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hbk_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hbk_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   localparam logic [hbk_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      hbk_pkg::QUEUE_PTR_W'(hbk_pkg::QUEUE_DEPTH - 1);
   localparam logic [hbk_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      hbk_pkg::QUEUE_CNT_W'(hbk_pkg::QUEUE_DEPTH);

   assign wr_ready = (count_ff != FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

/* hw/rtl/hbk_back.sv */
module hbk_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  hbk_pkg::entry_type                pop_entry,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hbk_pkg::CODE_W-1:0]        scancode,
   output logic                              shift_held,
   output logic                              ctrl_held,
   output logic                              alt_held,
   output logic                              last_of_report
);

   hbk_pkg::entry_type cur_ff, cur_in;
   logic [hbk_pkg::KEY_SLOTS-1:0] mask_ff, mask_in;
   logic [hbk_pkg::KEY_SLOTS-1:0] rest, mask_after;
   logic [hbk_pkg::SLOT_IDX_W-1:0] sel;
   logic out_free, emit, load;

   logic                       valid_ff, valid_in;
   logic [hbk_pkg::CODE_W-1:0] code_ff, code_in;
   logic                       shift_ff, shift_in;
   logic                       ctrl_ff, ctrl_in;
   logic                       alt_ff, alt_in;
   logic                       last_ff, last_in;

   // lowest pending slot goes first
   always_comb begin
      sel = '0;
      for (int i = hbk_pkg::KEY_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = hbk_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   assign rest = mask_ff & (mask_ff - 1'b1);
   assign out_free = !valid_ff || rsp_ready;
   assign emit = (|mask_ff) && out_free;
   assign mask_after = emit ? rest : mask_ff;
   assign load = (mask_after == '0) && pop_valid;
   assign pop_ready = load;

   always_comb begin
      mask_in = load ? pop_entry.fire : mask_after;
      cur_in = load ? pop_entry : cur_ff;
      valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      code_in = emit ? cur_ff.codes[sel] : code_ff;
      shift_in = emit ? cur_ff.shift : shift_ff;
      ctrl_in = emit ? cur_ff.ctrl : ctrl_ff;
      alt_in = emit ? cur_ff.alt : alt_ff;
      last_in = emit ? (rest == '0) : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      code_ff <= code_in;
      shift_ff <= shift_in;
      ctrl_ff <= ctrl_in;
      alt_ff <= alt_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign scancode = code_ff;
   assign shift_held = shift_ff;
   assign ctrl_held = ctrl_ff;
   assign alt_held = alt_ff;
   assign last_of_report = last_ff;

endmodule

/* hw/rtl/hid_boot_keyboard_to_scancode.sv */
// Converts USB HID boot keyboard reports into PS/2 set-1 make keycodes. Each report
// (modifiers and six usage slots) is compared with the previous one; every nonzero
// usage absent before and having a mapping (letters, digits, enter, esc, backspace,
// tab, space) gives one result, in slot order, carrying the report's shift, ctrl and
// alt flags and tlast on the final result of the report. A report is taken whenever
// the two-entry report queue has room; the serializer behind it sends one result per
// cycle while rsp_tready allows, so a report with n new mapped presses gives n results
// (up to six), and reports with none are taken but never enter the queue. A result
// passes through the report queue, the serializer register and the output register.
module hid_boot_keyboard_to_scancode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // modifiers, usage_slot0 .. usage_slot5
   input  logic [hbk_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // scancode, zero pad
   output logic [hbk_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // shift_held, ctrl_held, alt_held
   output logic [hbk_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   logic [hbk_pkg::MOD_W-1:0] modifiers;
   logic [hbk_pkg::KEY_SLOTS-1:0][hbk_pkg::USAGE_W-1:0] usages;
   logic push_valid, push_ready, pop_valid, pop_ready;
   hbk_pkg::entry_type push_entry, pop_entry;
   logic [hbk_pkg::CODE_W-1:0] scancode;
   logic shift_held, ctrl_held, alt_held;

   assign modifiers = req_tdata[hbk_pkg::MOD_W-1:0];
   always_comb begin
      for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
         usages[i] = req_tdata[hbk_pkg::MOD_W + i * hbk_pkg::USAGE_W +: hbk_pkg::USAGE_W];
      end
   end

   hbk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .modifiers  (modifiers),
      .usages     (usages),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   hbk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_entry (pop_entry)
   );

   hbk_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .scancode       (scancode),
      .shift_held     (shift_held),
      .ctrl_held      (ctrl_held),
      .alt_held       (alt_held),
      .last_of_report (rsp_tlast)
   );

   assign rsp_tdata = hbk_pkg::RSP_DATA_W'(scancode);
   assign rsp_tuser = {alt_held, ctrl_held, shift_held};

endmodule

/* hw/rtl/hbk_checker.sv */
module hbk_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [hbk_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hbk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [hbk_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata != '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid
         && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result dropped or changed while stalled");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[hbk_pkg::CODE_W-1:0] != '0)
         && (rsp_tdata[hbk_pkg::RSP_DATA_W-1:hbk_pkg::CODE_W] == '0))
      else $error("keycode out of range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

   // nothing can come out faster than queue, serializer register and output register
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $past(reset) ##1 !$past(req_seen) |-> !rsp_tvalid)
      else $error("result without a report");

endmodule

bind hid_boot_keyboard_to_scancode hbk_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* verif/hbk_keycode_checker.sv */
module hbk_keycode_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [hbk_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [hbk_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [hbk_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                            rsp_tlast,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = hbk_pkg::KEY_SLOTS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [6:0] scancode;
      logic       shift_held;
      logic       ctrl_held;
      logic       alt_held;
      logic       last_of_report;
   } key_event_type;

   localparam logic [6:0] LETTER_KEYCODES [26] = '{
      7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23, 7'h17, 7'h24, 7'h25,
      7'h26, 7'h32, 7'h31, 7'h18, 7'h19, 7'h10, 7'h13, 7'h1F, 7'h14, 7'h16, 7'h2F,
      7'h11, 7'h2D, 7'h15, 7'h2C
   };

   logic [7:0] held_keys [SLOTS];
   key_event_type expected_keys [$];

   function automatic logic [6:0] keycode_of(input logic [7:0] usage);
      if (usage >= hbk_pkg::USAGE_A && usage <= hbk_pkg::USAGE_Z) begin
         return LETTER_KEYCODES[5'(usage - hbk_pkg::USAGE_A)];
      end
      if (usage >= hbk_pkg::USAGE_1 && usage <= hbk_pkg::USAGE_9) begin
         return 7'(usage - hbk_pkg::USAGE_1 + 8'h02);
      end
      case (usage)
         hbk_pkg::USAGE_0:     return 7'h0B;
         hbk_pkg::USAGE_ENTER: return 7'h1C;
         hbk_pkg::USAGE_ESC:   return 7'h01;
         hbk_pkg::USAGE_BKSP:  return 7'h0E;
         hbk_pkg::USAGE_TAB:   return 7'h0F;
         hbk_pkg::USAGE_SPACE: return 7'h39;
         default:              return 7'h00;
      endcase
   endfunction

   function automatic bit was_down(input logic [7:0] usage);
      foreach (held_keys[j]) begin
         if (held_keys[j] == usage) return 1'b1;
      end
      return 1'b0;
   endfunction

   // new presses of one report, in slot order; the report then replaces the held keys
   function automatic void predict_presses(input logic [hbk_pkg::REQ_DATA_W-1:0] report);
      logic [7:0] mods;
      logic [7:0] now_down [SLOTS];
      logic [6:0] code;
      key_event_type ev;
      int         first;
      mods = report[7:0];
      first = expected_keys.size();
      for (int i = 0; i < SLOTS; i++) begin
         now_down[i] = report[8*(i+1) +: 8];
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (now_down[i] != 8'h00 && !was_down(now_down[i])) begin
            code = keycode_of(now_down[i]);
            if (code != 7'h00) begin
               ev.scancode = code;
               ev.shift_held = |(mods & 8'h22);
               ev.ctrl_held = |(mods & 8'h11);
               ev.alt_held = |(mods & 8'h44);
               ev.last_of_report = 1'b0;
               expected_keys.push_back(ev);
            end
         end
      end
      if (expected_keys.size() > first) begin
         expected_keys[expected_keys.size()-1].last_of_report = 1'b1;
      end
      for (int i = 0; i < SLOTS; i++) begin
         held_keys[i] = now_down[i];
      end
   endfunction

   function automatic void flag_failure(input string what, input key_event_type want,
                                        input key_event_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected %h s%b c%b a%b l%b, got %h s%b c%b a%b l%b",
                  $realtime, what, want.scancode, want.shift_held, want.ctrl_held,
                  want.alt_held, want.last_of_report, got.scancode, got.shift_held,
                  got.ctrl_held, got.alt_held, got.last_of_report);
      end
   endfunction

   always @(posedge clock) begin
      key_event_type got;
      key_event_type want;
      if (reset) begin
         foreach (held_keys[i]) held_keys[i] = 8'h00;
         expected_keys.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.scancode = rsp_tdata[6:0];
            got.shift_held = rsp_tuser[0];
            got.ctrl_held = rsp_tuser[1];
            got.alt_held = rsp_tuser[2];
            got.last_of_report = rsp_tlast;
            if (expected_keys.size() == 0) begin
               flag_failure("unexpected item", '0, got);
            end else begin
               want = expected_keys.pop_front();
               if (got !== want) flag_failure("mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) predict_presses(req_tdata);
      end
      pending <= expected_keys.size();
   end

endmodule

/* verif/tb_hid_boot_keyboard_to_scancode.sv */
module tb_hid_boot_keyboard_to_scancode;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_PCT = 14;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [hbk_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [hbk_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [hbk_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                            rsp_tlast;

   int         fail_count;
   int         pending;
   bit         quiet = 1'b0;
   bit         hold_rsp = 1'b0;
   logic [7:0] typing [hbk_pkg::KEY_SLOTS];

   hid_boot_keyboard_to_scancode u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   hbk_keycode_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [hbk_pkg::REQ_DATA_W-1:0] pack_report(
      input logic [7:0] mods, input logic [7:0] s0, input logic [7:0] s1,
      input logic [7:0] s2, input logic [7:0] s3, input logic [7:0] s4,
      input logic [7:0] s5);
      return {s5, s4, s3, s2, s1, s0, mods};
   endfunction

   function automatic logic [7:0] pick_key();
      if ($urandom_range(99) < 85) return 8'($urandom_range(8'h2C, 8'h04));
      return 8'($urandom_range(255));
   endfunction

   // typing-like sequence: presses and releases on top of the keys still held
   function automatic logic [hbk_pkg::REQ_DATA_W-1:0] next_typing_report();
      case ($urandom_range(9))
         0, 1, 2, 3: typing[3'($urandom_range(5))] = pick_key();
         4, 5, 6:    typing[3'($urandom_range(5))] = 8'h00;
         7:          foreach (typing[i]) typing[i] = 8'h00;
         8:          foreach (typing[i]) typing[i] = pick_key();
         default:    ;
      endcase
      return pack_report(8'($urandom_range(255)), typing[0], typing[1], typing[2],
                         typing[3], typing[4], typing[5]);
   endfunction

   function automatic logic [hbk_pkg::REQ_DATA_W-1:0] noise_report();
      logic [hbk_pkg::REQ_DATA_W-1:0] report;
      report[7:0] = 8'($urandom_range(255));
      for (int i = 1; i <= hbk_pkg::KEY_SLOTS; i++) begin
         report[8*i +: 8] = ($urandom_range(9) < 3) ? 8'h00 : 8'($urandom_range(255));
      end
      return report;
   endfunction

   task automatic send_report(input logic [hbk_pkg::REQ_DATA_W-1:0] report);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= report;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clock);
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("hid_boot_keyboard_to_scancode test failed");
      $finish;
   end

   initial begin
      foreach (typing[i]) typing[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // key still down: nothing new
      send_report(pack_report(8'h20, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h01, 8'h1D, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'hFF, 8'h1E, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A));
      send_report(pack_report(8'h44, 8'h2B, 8'h2C, 8'h2D, 8'h03, 8'hFF, 8'h00));
      // repeated codes in one report
      send_report(pack_report(8'h00, 8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00));
      // unmapped key is remembered
      send_report(pack_report(8'h10, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h40, 8'h2D, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h08, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // rollover report, then the held key fires again
      send_report(pack_report(8'h80, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
      send_report(pack_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h11, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h22, 8'h03, 8'h1D, 8'h1E, 8'h26, 8'h27, 8'h2C));
      send_report(pack_report(8'h00, 8'h2D, 8'h2E, 8'hE0, 8'hE7, 8'hFF, 8'h80));
      send_report(pack_report(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2C));
      send_report(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(pack_report(8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04));
      send_report(pack_report(8'hAA, 8'h00, 8'h1D, 8'h00, 8'h29, 8'h00, 8'h2B));
      send_report(pack_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            hold_rsp = 1'b1;
            quiet = 1'b1;
         end
         if (n == 174 || n == 330) quiet = 1'b0;
         if (n == 250) quiet = 1'b1;
         if (n == 300) drain();
         if (n >= 150 && n < 174) begin
            foreach (typing[i]) typing[i] = 8'($urandom_range(8'h2C, 8'h04));
            send_report(pack_report(8'($urandom_range(255)), typing[0], typing[1],
                                    typing[2], typing[3], typing[4], typing[5]));
         end else if ($urandom_range(99) < 75) begin
            send_report(next_typing_report());
         end else begin
            send_report(noise_report());
         end
      end
      drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("hid_boot_keyboard_to_scancode test passed");
      end else begin
         $display("hid_boot_keyboard_to_scancode test failed");
      end
      $finish;
   end

endmodule
